// ===== hdl/midi_track_event_encoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the track event encoder checker
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_ENCODER_CORE_DEFINES_SVH
`define MIDI_TRACK_EVENT_ENCODER_CORE_DEFINES_SVH

// Assert a property on the rising clock edge, ignored while reset is held
`define MTEV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert a property on the rising clock edge, checked during reset as well
`define MTEV_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mtev_pkg.sv =====
// ----------------------------------------------------------------------------
// mtev_pkg
// Types and constants shared by the track event encoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtev_pkg;

  // Command codes
  localparam logic [3:0] CMD_NOTE_ON   = 4'd0;
  localparam logic [3:0] CMD_NOTE_OFF  = 4'd1;
  localparam logic [3:0] CMD_PROGRAM   = 4'd2;
  localparam logic [3:0] CMD_BEND      = 4'd3;
  localparam logic [3:0] CMD_CONTROL   = 4'd4;
  localparam logic [3:0] CMD_NRPN      = 4'd5;
  localparam logic [3:0] CMD_NRPN_LSB  = 4'd6;
  localparam logic [3:0] CMD_RPN       = 4'd7;
  localparam logic [3:0] CMD_RPN_LSB   = 4'd8;
  localparam logic [3:0] CMD_BANK      = 4'd9;
  localparam logic [3:0] CMD_TEMPO     = 4'd10;
  localparam logic [3:0] CMD_TIME_SIG  = 4'd11;
  localparam logic [3:0] CMD_TRACK_END = 4'd12;

  // Status bytes (upper nibble, channel ORed in below)
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [3:0] ST_CONTROL  = 4'hB;
  localparam logic [7:0] ST_META     = 8'hFF;

  // Meta event types
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_TIME_SIG = 8'h58;
  localparam logic [7:0] META_END      = 8'h2F;

  // Controller numbers
  localparam logic [6:0] CC_DATA_MSB = 7'd6;
  localparam logic [6:0] CC_DATA_LSB = 7'd38;
  localparam logic [6:0] CC_NRPN_MSB = 7'd99;
  localparam logic [6:0] CC_NRPN_LSB = 7'd98;
  localparam logic [6:0] CC_RPN_MSB  = 7'd101;
  localparam logic [6:0] CC_RPN_LSB  = 7'd100;
  localparam logic [6:0] CC_BANK_MSB = 7'd0;
  localparam logic [6:0] CC_BANK_LSB = 7'd32;

  // Variable-length quantity thresholds
  localparam logic [27:0] VLQ_LIM4 = 28'h01FFFFF;
  localparam logic [27:0] VLQ_LIM3 = 28'h0003FFF;
  localparam logic [27:0] VLQ_LIM2 = 28'h000007F;

  // Stream widths
  localparam int IN_DATA_W = 104;
  localparam int IN_USER_W = 4;

  // Control from the sequencer to the delta-time shifter
  typedef struct packed {
    logic        load;
    logic        advance;
    logic [27:0] value;
  } vlq_ctrl_t;

  // Status back from the delta-time shifter
  typedef struct packed {
    logic [7:0] data;
    logic       done;
  } vlq_stat_t;

endpackage

// ===== hdl/mtev_vlq.sv =====
// ----------------------------------------------------------------------------
// mtev_vlq
// Delta-time shifter: emits a 28-bit value as a variable-length quantity,
// one 7-bit group per step, most significant group first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtev_vlq (
  input  logic                clk,
  input  logic                rst,
  input  mtev_pkg::vlq_ctrl_t ctrl,
  output mtev_pkg::vlq_stat_t stat
);
  import mtev_pkg::*;

  logic [27:0] sh;
  logic [1:0]  cnt;
  logic [27:0] sh_load;
  logic [1:0]  cnt_load;

  // Left-align the top significant group and count the bytes to go
  always_comb begin
    if (ctrl.value > VLQ_LIM4) begin
      sh_load  = ctrl.value;
      cnt_load = 2'd3;
    end else if (ctrl.value > VLQ_LIM3) begin
      sh_load  = {ctrl.value[20:0], 7'd0};
      cnt_load = 2'd2;
    end else if (ctrl.value > VLQ_LIM2) begin
      sh_load  = {ctrl.value[13:0], 14'd0};
      cnt_load = 2'd1;
    end else begin
      sh_load  = {ctrl.value[6:0], 21'd0};
      cnt_load = 2'd0;
    end
  end

  // Hold the count; advance one group per step
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (ctrl.load) begin
      cnt <= cnt_load;
    end else if (ctrl.advance && cnt != 2'd0) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Shift the payload up by one group per step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sh <= sh_load;
    end else if (ctrl.advance) begin
      sh <= {sh[20:0], 7'd0};
    end
  end

  assign stat.data = {(cnt != 2'd0), sh[27:21]};
  assign stat.done = (cnt == 2'd0);

endmodule

// ===== hdl/midi_track_event_encoder_core.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_encoder_core
// Standard MIDI File track event encoder with running status.
// ----------------------------------------------------------------------------
// One event is taken on the slave stream and its track bytes leave on the
// master stream, one byte per cycle while the sink is ready, tlast on the
// final byte of the event. An event produces 2 to 19 bytes, the longest being
// an NRPN or RPN with a value lsb. Bytes leave through a single output byte
// register, and the delta-time shifter releases one 7-bit group per cycle
// while the sink is ready. Commands 13 to 15 are taken and produce nothing.
// The block takes no new event until the last byte of the current one has
// been loaded into the output register.
`timescale 1ns / 1ps

module midi_track_event_encoder_core (
  input  logic                           clk,
  input  logic                           rst,
  // delta_time[27:0], channel[31:28], number[45:32], value[53:46],
  // value_low[61:54], click_ticks[69:62], thirty_seconds[77:70],
  // tempo[101:78], zero fill [103:102]
  input  logic [mtev_pkg::IN_DATA_W-1:0] s_tdata,
  // command[3:0]
  input  logic [mtev_pkg::IN_USER_W-1:0] s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // out_byte[7:0]
  output logic [7:0]                     m_tdata,
  output logic                           m_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready
);
  import mtev_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELTA,
    ST_BODY
  } state_t;

  state_t      state;
  logic [7:0]  last_status;

  // Latched event
  logic [3:0]  cmd;
  logic [3:0]  chan;
  logic [13:0] number;
  logic [7:0]  value;
  logic [7:0]  value_low;
  logic [7:0]  click_ticks;
  logic [7:0]  thirty_seconds;
  logic [23:0] tempo;
  logic        skip_status;

  logic [1:0]  seg;
  logic [2:0]  idx;

  // Incoming fields
  logic [3:0]  in_cmd;
  logic [3:0]  in_chan;
  logic        in_known;
  logic        accept;
  logic [7:0]  in_status;
  logic [7:0]  in_new_status;
  logic        in_running;

  // Sequencer decode
  logic        out_free;
  logic [2:0]  body_len;
  logic [1:0]  seg_last;
  logic        body_end;
  logic        event_end;
  logic [7:0]  body_byte;
  logic        long_sig;
  logic        is_rpn;

  vlq_ctrl_t   vlq_ctrl;
  vlq_stat_t   vlq_stat;

  assign in_cmd   = s_tuser;
  assign in_chan  = s_tdata[31:28];
  assign in_known = (in_cmd <= CMD_TRACK_END);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Work out the status of the incoming event and whether it may run
  always_comb begin
    case (in_cmd)
      CMD_NOTE_ON:  in_status = {ST_NOTE_ON, in_chan};
      CMD_NOTE_OFF: in_status = {ST_NOTE_OFF, in_chan};
      CMD_PROGRAM:  in_status = {ST_PROGRAM, in_chan};
      CMD_BEND:     in_status = {ST_BEND, in_chan};
      CMD_CONTROL, CMD_NRPN, CMD_NRPN_LSB, CMD_RPN, CMD_RPN_LSB, CMD_BANK:
                    in_status = {ST_CONTROL, in_chan};
      default:      in_status = ST_META;
    endcase
    in_running    = (in_cmd <= CMD_BEND) && (in_status == last_status);
    in_new_status = in_known ? in_status : last_status;
  end

  // Segment and byte counts of the held event
  assign long_sig = (click_ticks != 8'd0) || (thirty_seconds != 8'd0);
  assign is_rpn   = (cmd == CMD_RPN) || (cmd == CMD_RPN_LSB);

  always_comb begin
    case (cmd)
      CMD_PROGRAM:  body_len = 3'd2;
      CMD_TEMPO:    body_len = 3'd6;
      CMD_TIME_SIG: body_len = long_sig ? 3'd7 : 3'd5;
      default:      body_len = 3'd3;
    endcase
    case (cmd)
      CMD_NRPN, CMD_RPN:         seg_last = 2'd2;
      CMD_NRPN_LSB, CMD_RPN_LSB: seg_last = 2'd3;
      CMD_BANK:                  seg_last = 2'd1;
      default:                   seg_last = 2'd0;
    endcase
  end

  assign body_end  = (idx == body_len - 3'd1);
  assign event_end = body_end && (seg == seg_last);

  // Select the byte after the delta time
  always_comb begin
    body_byte = 8'h00;
    case (cmd)
      CMD_NOTE_ON, CMD_NOTE_OFF, CMD_BEND, CMD_PROGRAM, CMD_CONTROL: begin
        case (idx)
          3'd0: begin
            case (cmd)
              CMD_NOTE_ON:  body_byte = {ST_NOTE_ON, chan};
              CMD_NOTE_OFF: body_byte = {ST_NOTE_OFF, chan};
              CMD_PROGRAM:  body_byte = {ST_PROGRAM, chan};
              CMD_BEND:     body_byte = {ST_BEND, chan};
              default:      body_byte = {ST_CONTROL, chan};
            endcase
          end
          3'd1:    body_byte = {1'b0, number[6:0]};
          default: body_byte = (cmd == CMD_BEND) ? {1'b0, number[13:7]}
                                                 : {1'b0, value[6:0]};
        endcase
      end
      CMD_NRPN, CMD_NRPN_LSB, CMD_RPN, CMD_RPN_LSB, CMD_BANK: begin
        case (idx)
          3'd0: body_byte = {ST_CONTROL, chan};
          3'd1: begin
            case (seg)
              2'd0: body_byte = (cmd == CMD_BANK) ? {1'b0, CC_BANK_MSB}
                              : (is_rpn ? {1'b0, CC_RPN_MSB} : {1'b0, CC_NRPN_MSB});
              2'd1: body_byte = (cmd == CMD_BANK) ? {1'b0, CC_BANK_LSB}
                              : (is_rpn ? {1'b0, CC_RPN_LSB} : {1'b0, CC_NRPN_LSB});
              2'd2: body_byte = {1'b0, CC_DATA_MSB};
              default: body_byte = {1'b0, CC_DATA_LSB};
            endcase
          end
          default: begin
            case (seg)
              2'd0:    body_byte = {1'b0, number[13:7]};
              2'd1:    body_byte = {1'b0, number[6:0]};
              2'd2:    body_byte = {1'b0, value[6:0]};
              default: body_byte = {1'b0, value_low[6:0]};
            endcase
          end
        endcase
      end
      CMD_TEMPO: begin
        case (idx)
          3'd0:    body_byte = ST_META;
          3'd1:    body_byte = META_TEMPO;
          3'd2:    body_byte = 8'd3;
          3'd3:    body_byte = tempo[23:16];
          3'd4:    body_byte = tempo[15:8];
          default: body_byte = tempo[7:0];
        endcase
      end
      CMD_TIME_SIG: begin
        case (idx)
          3'd0:    body_byte = ST_META;
          3'd1:    body_byte = META_TIME_SIG;
          3'd2:    body_byte = long_sig ? 8'd4 : 8'd2;
          3'd3:    body_byte = value;
          3'd4:    body_byte = value_low;
          3'd5:    body_byte = click_ticks;
          default: body_byte = thirty_seconds;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    body_byte = ST_META;
          3'd1:    body_byte = META_END;
          default: body_byte = 8'h00;
        endcase
      end
    endcase
  end

  // Drive the delta-time shifter
  always_comb begin
    vlq_ctrl.load    = (accept && in_known) ||
                       (state == ST_BODY && out_free && body_end && !event_end);
    vlq_ctrl.advance = (state == ST_DELTA) && out_free;
    vlq_ctrl.value   = accept ? s_tdata[27:0] : 28'd0;
  end

  mtev_vlq u_vlq (
    .clk  (clk),
    .rst  (rst),
    .ctrl (vlq_ctrl),
    .stat (vlq_stat)
  );

  // Sequencer, remembered status and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      last_status <= 8'h00;
      m_tvalid    <= 1'b0;
      m_tlast     <= 1'b0;
      m_tdata     <= 8'h00;
      seg         <= 2'd0;
      idx         <= 3'd0;
      skip_status <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          // Drop the last byte once the sink has taken it
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (accept && in_known) begin
            state       <= ST_DELTA;
            seg         <= 2'd0;
            skip_status <= in_running;
            last_status <= in_new_status;
          end
        end
        ST_DELTA: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= vlq_stat.data;
            m_tlast  <= 1'b0;
            if (vlq_stat.done) begin
              state <= ST_BODY;
              idx   <= (seg == 2'd0 && skip_status) ? 3'd1 : 3'd0;
            end
          end
        end
        ST_BODY: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= body_byte;
            m_tlast  <= event_end;
            if (event_end) begin
              state <= ST_IDLE;
            end else if (body_end) begin
              state <= ST_DELTA;
              seg   <= seg + 2'd1;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the event fields
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd            <= in_cmd;
      chan           <= in_chan;
      number         <= s_tdata[45:32];
      value          <= s_tdata[53:46];
      value_low      <= s_tdata[61:54];
      click_ticks    <= s_tdata[69:62];
      thirty_seconds <= s_tdata[77:70];
      tempo          <= s_tdata[101:78];
    end
  end

endmodule

// ===== hdl/mtev_checker.sv =====
// ----------------------------------------------------------------------------
// mtev_checker
// Port-level checks on the track event encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_track_event_encoder_core_defines.svh"

module mtev_checker (
  input logic         clk,
  input logic         rst,
  input logic [103:0] s_tdata,
  input logic [3:0]   s_tuser,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [7:0]   m_tdata,
  input logic         m_tlast,
  input logic         m_tvalid,
  input logic         m_tready
);
  import mtev_pkg::*;

  // A stalled output byte holds
  `MTEV_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output byte changed while stalled")

  // A known command closes the input until its bytes are out
  `MTEV_ASSERT(a_busy_after_event, s_tvalid && s_tready && s_tuser <= CMD_TRACK_END |=> !s_tready, "input open after accepting an event")

  // An unknown command produces nothing and leaves the input open
  `MTEV_ASSERT(a_unknown_drop, s_tvalid && s_tready && s_tuser > CMD_TRACK_END |=> s_tready, "input closed after an unknown command")

  // Reset leaves the output empty and the input open
  `MTEV_ASSERT_RST(a_reset_state, rst |=> !m_tvalid && s_tready, "bad state after reset")

endmodule

bind midi_track_event_encoder_core mtev_checker u_mtev_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the track event encoder: drives events on the
// slave stream, predicts the track bytes with running status and compares
// every byte and its tlast flag on the master stream, with random idling on
// both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mtev_pkg::*;

  localparam logic [3:0] CMD_FIELD_MAX = 4'hF;
  localparam int         RANDOM_EVENTS = 200;

  // One track event as presented on the slave stream
  typedef struct packed {
    logic [3:0]  command;
    logic [27:0] delta;
    logic [3:0]  channel;
    logic [13:0] number;
    logic [7:0]  value;
    logic [7:0]  value_low;
    logic [7:0]  click_ticks;
    logic [7:0]  thirty_seconds;
    logic [23:0] tempo;
  } track_event_t;

  // One expected byte of track data
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } track_byte_t;

  // Predicts the track bytes of each accepted event and checks the output
  class track_byte_checker;
    track_byte_t bytes_due[$];
    logic [7:0]  frame[$];
    logic [7:0]  last_status;
    int          errors;
    int          checked;

    function new();
      last_status = 8'h00;
      errors      = 0;
      checked     = 0;
    endfunction

    // Variable-length delta, most significant group first
    function void emit_delta(logic [27:0] t);
      if (t > VLQ_LIM4) frame.push_back({1'b1, t[27:21]});
      if (t > VLQ_LIM3) frame.push_back({1'b1, t[20:14]});
      if (t > VLQ_LIM2) frame.push_back({1'b1, t[13:7]});
      frame.push_back({1'b0, t[6:0]});
    endfunction

    // Drop the status when it repeats the last one sent
    function void emit_running(logic [7:0] st);
      if (st != last_status) begin
        last_status = st;
        frame.push_back(st);
      end
    endfunction

    function void emit_cc(logic [27:0] dt, logic [3:0] ch, logic [6:0] ctl,
                          logic [6:0] val);
      emit_delta(dt);
      last_status = {ST_CONTROL, ch};
      frame.push_back(last_status);
      frame.push_back({1'b0, ctl});
      frame.push_back({1'b0, val});
    endfunction

    // Meta events cancel running status
    function void emit_meta_head(logic [27:0] dt, logic [7:0] kind, logic [7:0] len);
      emit_delta(dt);
      last_status = ST_META;
      frame.push_back(ST_META);
      frame.push_back(kind);
      frame.push_back(len);
    endfunction

    // Encode an accepted request and queue its bytes
    function void note_event(track_event_t ev);
      logic        rpn;
      track_byte_t b;
      frame.delete();
      rpn = (ev.command == CMD_RPN) || (ev.command == CMD_RPN_LSB);
      case (ev.command)
        CMD_NOTE_ON, CMD_NOTE_OFF: begin
          emit_delta(ev.delta);
          emit_running({(ev.command == CMD_NOTE_ON) ? ST_NOTE_ON : ST_NOTE_OFF,
                        ev.channel});
          frame.push_back({1'b0, ev.number[6:0]});
          frame.push_back({1'b0, ev.value[6:0]});
        end
        CMD_PROGRAM: begin
          emit_delta(ev.delta);
          emit_running({ST_PROGRAM, ev.channel});
          frame.push_back({1'b0, ev.number[6:0]});
        end
        CMD_BEND: begin
          emit_delta(ev.delta);
          emit_running({ST_BEND, ev.channel});
          frame.push_back({1'b0, ev.number[6:0]});
          frame.push_back({1'b0, ev.number[13:7]});
        end
        CMD_CONTROL: begin
          emit_cc(ev.delta, ev.channel, ev.number[6:0], ev.value[6:0]);
        end
        CMD_NRPN, CMD_NRPN_LSB, CMD_RPN, CMD_RPN_LSB: begin
          emit_cc(ev.delta, ev.channel, rpn ? CC_RPN_MSB : CC_NRPN_MSB, ev.number[13:7]);
          emit_cc(28'd0, ev.channel, rpn ? CC_RPN_LSB : CC_NRPN_LSB, ev.number[6:0]);
          emit_cc(28'd0, ev.channel, CC_DATA_MSB, ev.value[6:0]);
          if (ev.command == CMD_NRPN_LSB || ev.command == CMD_RPN_LSB) begin
            emit_cc(28'd0, ev.channel, CC_DATA_LSB, ev.value_low[6:0]);
          end
        end
        CMD_BANK: begin
          emit_cc(ev.delta, ev.channel, CC_BANK_MSB, ev.number[13:7]);
          emit_cc(28'd0, ev.channel, CC_BANK_LSB, ev.number[6:0]);
        end
        CMD_TEMPO: begin
          emit_meta_head(ev.delta, META_TEMPO, 8'd3);
          frame.push_back(ev.tempo[23:16]);
          frame.push_back(ev.tempo[15:8]);
          frame.push_back(ev.tempo[7:0]);
        end
        CMD_TIME_SIG: begin
          // Short form when neither click nor thirty-second count is given
          if (ev.click_ticks != 8'd0 || ev.thirty_seconds != 8'd0) begin
            emit_meta_head(ev.delta, META_TIME_SIG, 8'd4);
            frame.push_back(ev.value);
            frame.push_back(ev.value_low);
            frame.push_back(ev.click_ticks);
            frame.push_back(ev.thirty_seconds);
          end else begin
            emit_meta_head(ev.delta, META_TIME_SIG, 8'd2);
            frame.push_back(ev.value);
            frame.push_back(ev.value_low);
          end
        end
        CMD_TRACK_END: begin
          emit_meta_head(ev.delta, META_END, 8'd0);
        end
        default: begin
          // Unknown commands: no bytes, status kept
        end
      endcase
      foreach (frame[k]) begin
        b.data = frame[k];
        b.last = (k == frame.size() - 1);
        bytes_due.push_back(b);
      end
    endfunction

    // Compare one output byte with the oldest expected one
    function void check_byte(logic [7:0] data, logic last);
      track_byte_t exp_b;
      checked++;
      if (bytes_due.size() == 0) begin
        errors++;
        $display("%0t: ERROR unexpected byte, expected none, got data %02h last %0b",
                 $time, data, last);
        return;
      end
      exp_b = bytes_due.pop_front();
      if (exp_b.data !== data) begin
        errors++;
        $display("%0t: ERROR byte %0d data, expected %02h, got %02h",
                 $time, checked, exp_b.data, data);
      end
      if (exp_b.last !== last) begin
        errors++;
        $display("%0t: ERROR byte %0d last, expected %0b, got %0b",
                 $time, checked, exp_b.last, last);
      end
    endfunction

    function int pending();
      return bytes_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           m_tdata;
  logic                 m_tlast;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;

  track_byte_checker    sb;
  int                   events_sent;
  int                   unknown_sent;

  midi_track_event_encoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic track_event_t make_event(logic [3:0] cmd, logic [27:0] dt,
      logic [3:0] ch, logic [13:0] num, logic [7:0] val, logic [7:0] vlo,
      logic [7:0] clicks, logic [7:0] t32, logic [23:0] tmp);
    track_event_t ev;
    ev.command        = cmd;
    ev.delta          = dt;
    ev.channel        = ch;
    ev.number         = num;
    ev.value          = val;
    ev.value_low      = vlo;
    ev.click_ticks    = clicks;
    ev.thirty_seconds = t32;
    ev.tempo          = tmp;
    return ev;
  endfunction

  // Present one request after a random gap and hold it until accepted.
  // Entered and left just after a falling edge.
  task automatic send_event(track_event_t ev);
    int gap;
    gap = ((events_sent % 48) < 12) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev.command;
    s_tdata  <= {2'b00, ev.tempo, ev.thirty_seconds, ev.click_ticks, ev.value_low,
                 ev.value, ev.number, ev.channel, ev.delta};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_event(ev);
    events_sent++;
    if (ev.command > CMD_TRACK_END) unknown_sent++;
    @(negedge clk);
  endtask

  // Sink side: random stalls per byte, with stretches of none
  initial begin
    int stall;
    int byte_idx;
    byte_idx = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = ((byte_idx % 64) < 16) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_byte(m_tdata, m_tlast);
      byte_idx++;
      @(negedge clk);
    end
  end

  // Stimulus and end of run
  initial begin
    track_event_t ev;
    logic [3:0]   prev_cmd;
    logic [3:0]   prev_ch;
    int           valid_count;
    int           r;
    sb           = new();
    events_sent  = 0;
    unknown_sent = 0;
    valid_count  = 0;
    prev_cmd     = CMD_NOTE_ON;
    prev_ch      = 4'd0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: status after reset, running status, delta length edges,
    // masking, every command, both time signature forms, unknown commands
    send_event(make_event(CMD_NOTE_ON,  28'd0,        4'd0,  14'd60,    8'd100, 8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_NOTE_ON,  28'h000007F,  4'd0,  14'h3FFF,  8'hFF,  8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF));
    send_event(make_event(CMD_NOTE_OFF, 28'h0000080,  4'd0,  14'd60,    8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_NOTE_OFF, 28'h0003FFF,  4'd0,  14'd61,    8'd64,  8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_PROGRAM,  28'h0004000,  4'd5,  14'h3F80,  8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_PROGRAM,  28'h01FFFFF,  4'd5,  14'd127,   8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_BEND,     28'h0200000,  4'd5,  14'h3FFF,  8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_BEND,     28'hFFFFFFF,  4'd5,  14'd0,     8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_CONTROL,  28'd1,        4'd15, 14'h3FFF,  8'hFF,  8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_CONTROL,  28'd0,        4'd15, 14'd7,     8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_NOTE_ON,  28'd0,        4'd15, 14'd0,     8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_NRPN,     28'd200,      4'd3,  14'h2AD5,  8'hFF,  8'hFF, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_NRPN_LSB, 28'd0,        4'd3,  14'h3FFF,  8'h80,  8'hFF, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_RPN,      28'h3FFF,     4'd9,  14'd0,     8'd2,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_RPN_LSB,  28'hFFFFFFF,  4'd15, 14'h3FFF,  8'hFF,  8'hFF, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_BANK,     28'd5,        4'd1,  14'h3FFF,  8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_TEMPO,    28'd0,        4'd0,  14'd0,     8'd0,   8'd0, 8'd0, 8'd0, 24'hFFFFFF));
    send_event(make_event(CMD_TEMPO,    28'hFFFFFFF,  4'd0,  14'd0,     8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_TIME_SIG, 28'd0,        4'd0,  14'd0,     8'd4,   8'd2, 8'd24, 8'd8, 24'd0));
    send_event(make_event(CMD_TIME_SIG, 28'd96,       4'd0,  14'd0,     8'hFF,  8'hFF, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_TIME_SIG, 28'd0,        4'd0,  14'd0,     8'd3,   8'd3, 8'd0, 8'hFF, 24'd0));
    send_event(make_event(CMD_TRACK_END, 28'd0,       4'd0,  14'd0,     8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_NOTE_ON,  28'd10,       4'd2,  14'd64,    8'd90,  8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_TRACK_END + 4'd1, 28'hFFFFFFF, 4'd2, 14'h3FFF, 8'hFF, 8'hFF, 8'hFF,
                          8'hFF, 24'hFFFFFF));
    send_event(make_event(CMD_FIELD_MAX, 28'd0,       4'd7,  14'd0,     8'd0,   8'd0, 8'd0, 8'd0, 24'd0));
    send_event(make_event(CMD_NOTE_ON,  28'd0,        4'd2,  14'd65,    8'd91,  8'd0, 8'd0, 8'd0, 24'd0));

    // Let the directed part drain completely before going random
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);

    // Random events; repeated commands and channels build running-status runs
    while (valid_count < RANDOM_EVENTS) begin
      r = $urandom_range(0, 99);
      if (r < 5) ev.command = 4'($urandom_range(CMD_TRACK_END + 1, CMD_FIELD_MAX));
      else if (r < 40) ev.command = prev_cmd;
      else ev.command = 4'($urandom_range(CMD_NOTE_ON, CMD_TRACK_END));
      case ($urandom_range(0, 3))
        0: ev.delta = 28'($urandom_range(0, VLQ_LIM2));
        1: ev.delta = 28'($urandom_range(0, VLQ_LIM3));
        2: ev.delta = 28'($urandom_range(0, VLQ_LIM4));
        default: ev.delta = 28'($urandom);
      endcase
      ev.channel        = ($urandom_range(0, 9) < 7) ? prev_ch : 4'($urandom);
      ev.number         = 14'($urandom);
      ev.value          = 8'($urandom);
      ev.value_low      = 8'($urandom);
      ev.click_ticks    = 8'($urandom);
      ev.thirty_seconds = 8'($urandom);
      ev.tempo          = 24'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        ev.click_ticks    = 8'd0;
        ev.thirty_seconds = ($urandom_range(0, 1) == 0) ? 8'd0 : ev.thirty_seconds;
      end
      send_event(ev);
      if (ev.command <= CMD_TRACK_END) begin
        valid_count++;
        prev_cmd = ev.command;
      end
      prev_ch = ev.channel;
      // Hold the source once mid-run until the sink has caught up
      if (valid_count == RANDOM_EVENTS / 2 && ev.command <= CMD_TRACK_END) begin
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then watch for stray bytes
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run covered %0d events (%0d with unknown commands), %0d output bytes checked",
             events_sent, unknown_sent, sb.checked);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== midi_track_event_encoder_core.f =====
+incdir+hdl
hdl/mtev_pkg.sv
hdl/mtev_vlq.sv
hdl/midi_track_event_encoder_core.sv
hdl/mtev_checker.sv
bench/tb_top.sv
